// ===== rtl/twsm_pkg.sv =====
// Shared types and codes for the two-way sorted merge block.
// No dependencies; imported by the controller and the top level.

package twsm_pkg;

   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;

   typedef logic [OP_W-1:0]    op_type;
   typedef logic [VALUE_W-1:0] value_type;

   localparam op_type OP_LOAD_FIRST  = 2'd0;
   localparam op_type OP_LOAD_SECOND = 2'd1;
   localparam op_type OP_MERGE       = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } state_type;

endpackage

// ===== rtl/twsm_ram.sv =====
// Single-write, single-read list buffer with registered read data.
// No package dependencies; instantiated once per list by the top level.

module twsm_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/twsm_ctrl.sv =====
// Load/merge sequencer: list counts, read pointers, head compare and output register.
// Depends on twsm_pkg; drives the two twsm_ram list buffers.

module twsm_ctrl #(
   parameter int LIST_DEPTH = 16,
   parameter int ADDR_W     = 4,
   parameter int CNT_W      = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  twsm_pkg::op_type         req_op,
   input  twsm_pkg::value_type      req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output twsm_pkg::value_type      rsp_value,
   output logic                     rsp_from_second,
   output logic                     rsp_last,
   output logic                     rsp_overflow,
   output logic                     wr_en1,
   output logic                     wr_en2,
   output logic [ADDR_W-1:0]        wr_addr1,
   output logic [ADDR_W-1:0]        wr_addr2,
   output twsm_pkg::value_type      wr_data,
   output logic [ADDR_W-1:0]        rd_addr1,
   output logic [ADDR_W-1:0]        rd_addr2,
   input  twsm_pkg::value_type      rd_data1,
   input  twsm_pkg::value_type      rd_data2
);

   import twsm_pkg::*;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt1_ff, cnt1_in;
   logic [CNT_W-1:0] cnt2_ff, cnt2_in;
   logic [CNT_W-1:0] idx1_ff, idx1_in;
   logic [CNT_W-1:0] idx2_ff, idx2_in;
   logic             dropped_ff, dropped_in;
   logic             out_valid_ff, out_valid_in;
   value_type        out_value_ff, out_value_in;
   logic             out_second_ff, out_second_in;
   logic             out_last_ff, out_last_in;
   logic             out_ovf_ff, out_ovf_in;

   logic             accept;
   logic             emit;
   logic             take_first;
   logic             run_last;
   logic [CNT_W:0]   done_cnt;
   logic [CNT_W:0]   total_cnt;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // heads are the registered reads at idx1/idx2
   assign take_first = (idx1_ff < cnt1_ff) &&
                       ((idx2_ff >= cnt2_ff) || ($signed(rd_data1) < $signed(rd_data2)));
   assign emit       = (state_ff == ST_MERGE) && (!out_valid_ff || rsp_ready);
   assign done_cnt   = {1'b0, idx1_ff} + {1'b0, idx2_ff} + (CNT_W+1)'(1);
   assign total_cnt  = {1'b0, cnt1_ff} + {1'b0, cnt2_ff};
   assign run_last   = (done_cnt == total_cnt);

   always_comb begin
      state_in      = state_ff;
      cnt1_in       = cnt1_ff;
      cnt2_in       = cnt2_ff;
      idx1_in       = idx1_ff;
      idx2_in       = idx2_ff;
      dropped_in    = dropped_ff;
      wr_en1        = 1'b0;
      wr_en2        = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_value_in  = out_value_ff;
      out_second_in = out_second_ff;
      out_last_in   = out_last_ff;
      out_ovf_in    = out_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_LOAD_FIRST: begin
                     if (cnt1_ff < FULL_CNT) begin
                        wr_en1  = 1'b1;
                        cnt1_in = cnt1_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_LOAD_SECOND: begin
                     if (cnt2_ff < FULL_CNT) begin
                        wr_en2  = 1'b1;
                        cnt2_in = cnt2_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  OP_MERGE: begin
                     if ((cnt1_ff != '0) || (cnt2_ff != '0)) begin
                        state_in = ST_MERGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if (emit) begin
               out_valid_in  = 1'b1;
               out_value_in  = take_first ? rd_data1 : rd_data2;
               out_second_in = !take_first;
               out_last_in   = run_last;
               out_ovf_in    = dropped_ff;
               if (take_first) begin
                  idx1_in = idx1_ff + CNT_W'(1);
               end else begin
                  idx2_in = idx2_ff + CNT_W'(1);
               end
               if (run_last) begin
                  state_in   = ST_IDLE;
                  cnt1_in    = '0;
                  cnt2_in    = '0;
                  idx1_in    = '0;
                  idx2_in    = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt1_ff      <= '0;
         cnt2_ff      <= '0;
         idx1_ff      <= '0;
         idx2_ff      <= '0;
         dropped_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt1_ff      <= cnt1_in;
         cnt2_ff      <= cnt2_in;
         idx1_ff      <= idx1_in;
         idx2_ff      <= idx2_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      out_second_ff <= out_second_in;
      out_last_ff   <= out_last_in;
      out_ovf_ff    <= out_ovf_in;
   end

   // read at the next pointer so the head is ready in the cycle after
   assign rd_addr1 = idx1_in[ADDR_W-1:0];
   assign rd_addr2 = idx2_in[ADDR_W-1:0];
   assign wr_addr1 = cnt1_ff[ADDR_W-1:0];
   assign wr_addr2 = cnt2_ff[ADDR_W-1:0];
   assign wr_data  = req_value;

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_from_second = out_second_ff;
   assign rsp_last        = out_last_ff;
   assign rsp_overflow    = out_ovf_ff;

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      (idx1_ff <= cnt1_ff) && (idx2_ff <= cnt2_ff))
      else $error("read pointer ran past list count");

   a_idle_ptrs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((idx1_ff == '0) && (idx2_ff == '0)))
      else $error("read pointers not rewound while idle");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (emit && run_last) |=> ((state_ff == ST_IDLE) && (cnt1_ff == '0) &&
                              (cnt2_ff == '0) && !dropped_ff))
      else $error("final merge word did not empty both lists");

   a_merge_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (total_cnt != '0))
      else $error("merge running with both lists empty");

   a_no_load_in_merge: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (!wr_en1 && !wr_en2))
      else $error("buffer written during merge");

endmodule

// ===== rtl/two_way_sorted_merge.sv =====
// Two-way sorted merge: channels (req_/rsp_), list buffers and merge sequencer.
// Depends on twsm_pkg, twsm_ram and twsm_ctrl.
//
// Usage:
//   req_ channel: tuser carries the op (append to first list, append to second
//   list, start merge), tdata the signed 32-bit value to append. Loads give no
//   word; a load into a full list is dropped and flagged.
//   A start with both lists empty gives nothing. Otherwise the block drops
//   req_tready and emits first_count + second_count words on rsp_, ascending by
//   signed head compare (ties to the second list), tlast on the final word.
//   tuser[1] (overflow) repeats on every word of the run, then clears.
//   Sequence: the accepted start word sets the merge state, then the first word
//   enters the output register and raises rsp_tvalid; one word per cycle follows
//   while rsp_ is not stalled, paced by the single head compare and one read port
//   per list. req_tready stays low until the final word enters the output register.
//   Back-pressure: a stalled rsp_ word is held in the output register and the
//   sequencer waits; loads may be accepted while the final word still waits.
//   Reset (synchronous, active high) empties both lists and clears the flag;
//   buffer contents are not cleared and need no clearing pass.

module two_way_sorted_merge #(
   parameter int LIST_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] merged_value
   output logic [1:0]  rsp_tuser,   // [0] from_second, [1] overflow
   output logic        rsp_tlast
);

   import twsm_pkg::*;

   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

   logic              wr_en1, wr_en2;
   logic [ADDR_W-1:0] wr_addr1, wr_addr2;
   logic [ADDR_W-1:0] rd_addr1, rd_addr2;
   value_type         wr_data, rd_data1, rd_data2;
   value_type         rsp_value;
   logic              rsp_from_second, rsp_overflow;

   twsm_ram #(
      .DEPTH  (LIST_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_first_buf (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (wr_addr1),
      .wr_data (wr_data),
      .rd_addr (rd_addr1),
      .rd_data (rd_data1)
   );

   twsm_ram #(
      .DEPTH  (LIST_DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_second_buf (
      .clock   (clock),
      .wr_en   (wr_en2),
      .wr_addr (wr_addr2),
      .wr_data (wr_data),
      .rd_addr (rd_addr2),
      .rd_data (rd_data2)
   );

   twsm_ctrl #(
      .LIST_DEPTH (LIST_DEPTH),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_op          (op_type'(req_tuser)),
      .req_value       (value_type'(req_tdata)),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_value       (rsp_value),
      .rsp_from_second (rsp_from_second),
      .rsp_last        (rsp_tlast),
      .rsp_overflow    (rsp_overflow),
      .wr_en1          (wr_en1),
      .wr_en2          (wr_en2),
      .wr_addr1        (wr_addr1),
      .wr_addr2        (wr_addr2),
      .wr_data         (wr_data),
      .rd_addr1        (rd_addr1),
      .rd_addr2        (rd_addr2),
      .rd_data1        (rd_data1),
      .rd_data2        (rd_data2)
   );

   assign rsp_tdata = rsp_value;
   assign rsp_tuser = {rsp_overflow, rsp_from_second};

endmodule

// ===== tb/two_way_sorted_merge_tb.sv =====
// Self-checking testbench for two_way_sorted_merge: sorted list loads, merges, overflow.
// Depends on twsm_pkg and the two_way_sorted_merge RTL; a scoreboard class predicts words.
`timescale 1ns / 1ps

module two_way_sorted_merge_tb;
   import twsm_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam op_type OP_UNUSED = 2'd3;

   typedef struct packed {
      value_type merged_value;
      logic      from_second;
      logic      last;
      logic      overflow;
   } merged_word_type;

   class merge_scoreboard;
      value_type       first_list[LIST_DEPTH];
      value_type       second_list[LIST_DEPTH];
      int              first_len;
      int              second_len;
      bit              dropped;
      merged_word_type merged_q[$];
      int              fails;
      int              words_checked;
      int              merge_runs;
      int              overflow_runs;
      int              empty_starts;

      function new();
         first_len     = 0;
         second_len    = 0;
         dropped       = 1'b0;
         fails         = 0;
         words_checked = 0;
         merge_runs    = 0;
         overflow_runs = 0;
         empty_starts  = 0;
      endfunction

      function int pending();
         return merged_q.size();
      endfunction

      // One accepted input word: update the lists, queue the merged run on a start.
      function void note_word(op_type op, value_type value);
         int i;
         int j;
         int total;
         bit take_first;
         merged_word_type w;
         case (op)
            OP_LOAD_FIRST: begin
               if (first_len < LIST_DEPTH) begin
                  first_list[first_len] = value;
                  first_len++;
               end else begin
                  dropped = 1'b1;
               end
            end
            OP_LOAD_SECOND: begin
               if (second_len < LIST_DEPTH) begin
                  second_list[second_len] = value;
                  second_len++;
               end else begin
                  dropped = 1'b1;
               end
            end
            OP_MERGE: begin
               total = first_len + second_len;
               if (total == 0) begin
                  empty_starts++;
               end else begin
                  i = 0;
                  j = 0;
                  for (int k = 0; k < total; k++) begin
                     // ties go to the second list
                     take_first = (i < first_len) && ((j >= second_len) ||
                        ($signed(first_list[i]) < $signed(second_list[j])));
                     if (take_first) begin
                        w.merged_value = first_list[i];
                        w.from_second  = 1'b0;
                        i++;
                     end else begin
                        w.merged_value = second_list[j];
                        w.from_second  = 1'b1;
                        j++;
                     end
                     w.last     = (k == total - 1);
                     w.overflow = dropped;
                     merged_q.push_back(w);
                  end
                  merge_runs++;
                  if (dropped) overflow_runs++;
                  first_len  = 0;
                  second_len = 0;
                  dropped    = 1'b0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(value_type value, logic from_second, logic last,
                               logic overflow);
         merged_word_type w;
         if (merged_q.size() == 0) begin
            $error("unexpected word: value %0d", $signed(value));
            fails++;
            return;
         end
         w = merged_q.pop_front();
         words_checked++;
         if (value !== w.merged_value) begin
            $error("merged_value: expected %0d, got %0d",
                   $signed(w.merged_value), $signed(value));
            fails++;
         end
         if (from_second !== w.from_second) begin
            $error("from_second: expected %0b, got %0b", w.from_second, from_second);
            fails++;
         end
         if (last !== w.last) begin
            $error("last: expected %0b, got %0b", w.last, last);
            fails++;
         end
         if (overflow !== w.overflow) begin
            $error("overflow: expected %0b, got %0b", w.overflow, overflow);
            fails++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value
   logic [1:0]  req_tuser = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] merged_value
   logic [1:0]  rsp_tuser;        // [0] from_second, [1] overflow
   logic        rsp_tlast;

   merge_scoreboard board;
   int send_idle_pct = 35;
   int recv_idle_pct = 60;
   int hold_request  = 0;
   int hold_left     = 0;
   int items_sent    = 0;

   two_way_sorted_merge #(
      .LIST_DEPTH(LIST_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_word(rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
         if (req_tvalid && req_tready)
            board.note_word(req_tuser, req_tdata);
      end
   end

   task automatic send_word(op_type op, value_type value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   // style 0: full range, 1: narrow range with many ties, 2: mix with extremes
   function automatic int pick_element(int style);
      int pick;
      if (style == 1) return int'($urandom_range(0, 12)) - 6;
      if (style == 2) begin
         pick = $urandom_range(0, 4);
         case (pick)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3: return -1;
            default: return $urandom;
         endcase
      end
      return $urandom;
   endfunction

   // loads two sorted lists, interleaved at random, order within each list kept
   task automatic send_sorted_lists(int n1, int n2, int style);
      int a[$];
      int b[$];
      for (int k = 0; k < n1; k++) a.push_back(pick_element(style));
      for (int k = 0; k < n2; k++) b.push_back(pick_element(style));
      a.sort();
      b.sort();
      while (a.size() != 0 || b.size() != 0) begin
         if (b.size() == 0 || (a.size() != 0 && $urandom_range(0, 1) == 0))
            send_word(OP_LOAD_FIRST, a.pop_front());
         else
            send_word(OP_LOAD_SECOND, b.pop_front());
      end
   endtask

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return $urandom_range(0, 4);
      if (roll < 9) return $urandom_range(5, 10);
      return $urandom_range(11, LIST_DEPTH);
   endfunction

   task automatic random_sequence();
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         send_sorted_lists(pick_length(), pick_length(), $urandom_range(0, 2));
         send_word(OP_MERGE, $urandom);
      end else if (kind == 7) begin
         // noise: any op, unsorted values
         n = $urandom_range(1, 4);
         for (int k = 0; k < n; k++) send_word(op_type'($urandom_range(0, 3)), $urandom);
      end else if (kind == 8) begin
         // overrun one list, then merge
         n = LIST_DEPTH + $urandom_range(1, 3);
         if ($urandom_range(0, 1) == 0) send_sorted_lists(n, $urandom_range(0, 3), 0);
         else send_sorted_lists($urandom_range(0, 3), n, 0);
         send_word(OP_MERGE, $urandom);
      end else begin
         send_word(OP_UNUSED, $urandom);
         send_word(OP_MERGE, $urandom);
      end
   endtask

   initial begin
      int target;
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty start, unused op, extremes and ties, one-sided merges
      send_word(OP_MERGE, $urandom);
      send_word(OP_UNUSED, $urandom);
      send_word(OP_LOAD_FIRST, 32'h8000_0000);
      send_word(OP_LOAD_SECOND, 32'h0000_0000);
      send_word(OP_LOAD_FIRST, 32'hffff_ffff);
      send_word(OP_LOAD_SECOND, 32'h0000_0005);
      send_word(OP_LOAD_FIRST, 32'h0000_0005);
      send_word(OP_LOAD_SECOND, 32'h7fff_ffff);
      send_word(OP_MERGE, 32'hffff_ffff);
      send_word(OP_LOAD_SECOND, 32'h0000_0007);
      send_word(OP_LOAD_SECOND, 32'h0000_0009);
      send_word(OP_MERGE, 32'h0);
      send_word(OP_LOAD_FIRST, 32'h1234_5678);
      send_word(OP_MERGE, $urandom);

      // long receiver hold-off during a big merge while loads keep coming
      send_sorted_lists(10, 10, 0);
      hold_request = 400;
      send_word(OP_MERGE, $urandom);
      for (int k = 0; k < 4; k++) send_word(op_type'($urandom_range(0, 1)), $urandom);
      req_tvalid <= 1'b0;
      wait_drained();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 35; recv_idle_pct = 60; end
            1: begin send_idle_pct = 60; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         target = items_sent + 55;
         while (items_sent < target) random_sequence();
      end
      // flush anything the noise left in the lists
      send_word(OP_MERGE, $urandom);
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d input words, %0d merge runs (%0d with overflow), %0d empty starts",
               items_sent, board.merge_runs, board.overflow_runs, board.empty_starts);
      $display("checked %0d merged words", board.words_checked);
      if (board.fails == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting for the merge to drain");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
